// ===== design/vtdt_pkg.sv =====
`timescale 1ns / 1ps

package vtdt_pkg;

  // fixed field widths of a transaction
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned VID_W       = 10;
  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [FIELD_W-1:0] position_index;
    logic [FIELD_W-1:0] texcoord_index;
    logic [FIELD_W-1:0] normal_index;
  } vtdt_req_t;

  typedef struct packed {
    logic [VID_W-1:0] vertex_id;
    logic             is_new;
    logic             table_full;
  } vtdt_res_t;

endpackage

// ===== design/vertex_triple_dedup_table.sv =====
`timescale 1ns / 1ps
// flow: a taken triple waits in the front's holding stage and the queue; the back reads its
//   home slot and each further slot probed (linear probing in the slot memory) until a hit
//   or an empty slot, then registers done; it takes one triple at a time, the front more;
//   busy falls once the queue has room; the receiver cannot stall the done strobe
// reset: asynchronous, clears the vertex count and control state, then a clearing pass over
//   all 2^ceil(log2(2*CAPACITY)) slots (2048 by default) empties them with busy held high
module vertex_triple_dedup_table #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  vtdt_pkg::vtdt_req_t req_i,
  output logic                done_o,
  output vtdt_pkg::vtdt_res_t res_o
);
  import vtdt_pkg::*;

  // open-addressed hash table at least twice the capacity, so that a probe
  // sequence always ends at a hit or an empty slot even when full
  localparam int unsigned SLOT_BITS = $clog2(2 * CAPACITY);
  localparam int unsigned KEY_W     = 3 * INDEX_BITS;
  localparam int unsigned QW        = KEY_W + SLOT_BITS;

  logic          clearing;
  logic          queue_full, queue_empty;
  logic          push, pop;
  logic [QW-1:0] push_data, pop_data;

  // front: takes the transaction, masks the indices and hashes the key
  vtdt_front #(
    .INDEX_BITS (INDEX_BITS),
    .SLOT_BITS  (SLOT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .clearing_i   (clearing),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // short queue so the front keeps taking transactions while the back probes
  vtdt_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (pop),
    .empty_o     (queue_empty),
    .pop_data_o  (pop_data)
  );

  // back: probes the slot memory, inserts new triples, issues the result
  vtdt_back #(
    .CAPACITY   (CAPACITY),
    .INDEX_BITS (INDEX_BITS),
    .SLOT_BITS  (SLOT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (queue_empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule

// ===== design/vtdt_front.sv =====
`timescale 1ns / 1ps

module vtdt_front #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned SLOT_BITS  = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  vtdt_pkg::vtdt_req_t                 req_i,
  input  logic                                clearing_i,
  input  logic                                queue_full_i,
  output logic                                push_o,
  output logic [3*INDEX_BITS+SLOT_BITS-1:0]   push_data_o
);
  import vtdt_pkg::*;

  localparam int unsigned KEY_W = 3 * INDEX_BITS;

  logic              accept;
  logic              valid_q, valid_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [SLOT_BITS-1:0] hash_q, hash_d;
  logic [31:0]       pos_ext, tex_ext, nrm_ext;

  // one holding stage, emptied into the queue when it has room
  assign push_o      = valid_q && !queue_full_i;
  assign busy        = clearing_i || (valid_q && queue_full_i);
  assign accept      = start && !busy;
  assign push_data_o = {key_q, hash_q};

  // indices reduced or zero extended to the stored width
  assign pos_ext = {16'b0, req_i.position_index};
  assign tex_ext = {16'b0, req_i.texcoord_index};
  assign nrm_ext = {16'b0, req_i.normal_index};
  assign key_d   = {pos_ext[INDEX_BITS-1:0], tex_ext[INDEX_BITS-1:0],
                    nrm_ext[INDEX_BITS-1:0]};

  // spread and fold the key into a slot number
  always_comb begin
    hash_d = '0;
    for (int i = 0; i < KEY_W; i++) begin
      hash_d[(i * 7) % SLOT_BITS] = hash_d[(i * 7) % SLOT_BITS] ^ key_d[i];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      key_q   <= '0;
      hash_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        key_q  <= key_d;
        hash_q <= hash_d;
      end
    end
  end

endmodule

// ===== design/vtdt_queue.sv =====
`timescale 1ns / 1ps

module vtdt_queue #(
  parameter int unsigned WIDTH = 59
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] pop_data_o
);
  import vtdt_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/vtdt_back.sv =====
`timescale 1ns / 1ps

module vtdt_back #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned SLOT_BITS  = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                empty_i,
  input  logic [3*INDEX_BITS+SLOT_BITS-1:0]   pop_data_i,
  output logic                                pop_o,
  output logic                                clearing_o,
  output logic                                done_o,
  output vtdt_pkg::vtdt_res_t                 res_o
);
  import vtdt_pkg::*;

  localparam int unsigned KEY_W   = 3 * INDEX_BITS;
  localparam int unsigned ID_W    = $clog2(CAPACITY);
  localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SLOTS   = 1 << SLOT_BITS;
  localparam int unsigned ENTRY_W = 1 + KEY_W + ID_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK
  } state_e;

  state_e               state_q;
  logic [SLOT_BITS-1:0] probe_q;
  logic [COUNT_W-1:0]   count_q;
  logic [KEY_W-1:0]     key_q;
  logic                 done_q;
  vtdt_res_t            res_q;

  logic [ENTRY_W-1:0]   slot_mem [SLOTS];
  logic [ENTRY_W-1:0]   rd_data_q;
  logic                 wr_en;
  logic [ENTRY_W-1:0]   wr_data;

  logic                 ent_valid, ent_hit, tbl_full;
  logic [KEY_W-1:0]     ent_key;
  logic [ID_W-1:0]      ent_id, new_id;
  logic [31:0]          hit_vid_ext, new_vid_ext;

  assign ent_valid = rd_data_q[ENTRY_W-1];
  assign ent_key   = rd_data_q[ID_W +: KEY_W];
  assign ent_id    = rd_data_q[ID_W-1:0];
  assign ent_hit   = ent_valid && (ent_key == key_q);
  assign tbl_full  = (count_q == COUNT_W'(CAPACITY));
  assign new_id    = count_q[ID_W-1:0];

  assign hit_vid_ext = 32'(ent_id);
  assign new_vid_ext = 32'(new_id);

  // clearing pass writes empty slots; an insert fills the empty slot found
  assign wr_en   = (state_q == S_CLEAR) ||
                   ((state_q == S_CHECK) && !ent_valid && !tbl_full);
  assign wr_data = (state_q == S_CLEAR) ? '0 : {1'b1, key_q, new_id};

  assign pop_o      = (state_q == S_IDLE) && !empty_i;
  assign clearing_o = (state_q == S_CLEAR);
  assign done_o     = done_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[probe_q] <= wr_data;
    end
    rd_data_q <= slot_mem[probe_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      probe_q <= '0;
      count_q <= '0;
      key_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          probe_q <= probe_q + 1'b1;
          if (probe_q == SLOT_BITS'(SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty_i) begin
            key_q   <= pop_data_i[SLOT_BITS +: KEY_W];
            probe_q <= pop_data_i[SLOT_BITS-1:0];
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (ent_hit) begin
            done_q           <= 1'b1;
            res_q.vertex_id  <= hit_vid_ext[VID_W-1:0];
            res_q.is_new     <= 1'b0;
            res_q.table_full <= 1'b0;
            state_q          <= S_IDLE;
          end else if (ent_valid) begin
            probe_q <= probe_q + 1'b1;
            state_q <= S_READ;
          end else if (tbl_full) begin
            done_q           <= 1'b1;
            res_q.vertex_id  <= '0;
            res_q.is_new     <= 1'b0;
            res_q.table_full <= 1'b1;
            state_q          <= S_IDLE;
          end else begin
            done_q           <= 1'b1;
            res_q.vertex_id  <= new_vid_ext[VID_W-1:0];
            res_q.is_new     <= 1'b1;
            res_q.table_full <= 1'b0;
            count_q          <= count_q + 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
